// File: hw/rtl/tstg_pkg.sv
package tstg_pkg;

    localparam int FREQ_W  = 13;
    localparam int TF_W    = 16;
    localparam int DIV_W   = 8;
    localparam int BAR_W   = 8;
    localparam int HP_W    = 19;
    localparam int TOT_W   = 22;
    localparam int GAP_W   = 9;
    localparam int LVL_W   = 7;
    localparam int BASE_W  = 8;
    localparam int LEN_W   = 8;
    localparam int REST_W  = 16;
    localparam int PROD_W  = 24;
    localparam int DVD_W   = 24;
    localparam int DVS_W   = 16;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 8;

    localparam logic [TOT_W-1:0]  TOT_MAX        = {TOT_W{1'b1}};
    localparam int                HALF_SCALE     = 500000;
    localparam int                TRANSPOSE_STEP = 200;
    localparam int                BAR_STEP       = 625;
    localparam int                CYC_SCALE      = 100;
    localparam int                GAP_NUM        = 13;
    localparam int                GAP_DEN        = 10;
    localparam logic [BASE_W-1:0] BASE_RESET     = 8'd110;

    // Rounded-up reciprocals for the divisions by 10 and by 100. Both are exact
    // over the dividend ranges that the note engine can produce.
    localparam int GAP_RECIP   = 52429;
    localparam int GAP_SHIFT   = 19;
    localparam int GAP_PROD_W  = 28;
    localparam int TOT_RECIP   = 21474837;
    localparam int TOT_SHIFT   = 31;
    localparam int TOT_RECIP_W = 25;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TRANSPOSE = 1'b0,
        CFG_BASE      = 1'b1
    } t_cfg_idx;

    // One queued command as classified by the front end.
    typedef struct packed {
        logic              is_start;
        logic [TF_W-1:0]   freq;
        logic [DIV_W-1:0]  divisor;
        logic [BAR_W-1:0]  bar;
    } t_cmd;

endpackage

// File: hw/rtl/tstg_div.sv
module tstg_div
    import tstg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dsr;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign ge    = (trial >= {1'b0, r_dsr});
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done lasted more than one cycle");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while a division was running");

endmodule

// File: hw/rtl/tstg_front.sv
module tstg_front
    import tstg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LVL_W-1:0]  i_level,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [FREQ_W-1:0] i_note_frequency,
    input  logic [DIV_W-1:0]  i_note_divisor,
    output t_cmd              o_head,
    output logic              o_head_valid,
    input  logic              i_pop
);

    localparam int QDEPTH = 2;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    function automatic logic [BAR_W-1:0] bar_of(input logic [TF_W-1:0] f);
        logic [2:0] step;
        step = '0;
        for (int k = 1; k < BAR_W; k++) begin
            if (f >= TF_W'(k * BAR_STEP)) begin
                step = 3'(k);
            end
        end
        return BAR_W'(1) << step;
    endfunction

    t_cmd              r_q [QDEPTH];
    logic [QIDX_W-1:0] r_wr;
    logic [QIDX_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    logic              push;
    logic [TF_W-1:0]   tfreq;
    t_cmd              cmd;

    assign o_in_stall = (r_count == QCNT_W'(QDEPTH));
    assign push       = i_in_valid && !o_in_stall;

    assign tfreq = TF_W'(i_note_frequency)
                 + TF_W'(i_level) * TF_W'(TRANSPOSE_STEP);

    always_comb begin
        cmd.is_start = (i_opcode == OP_START);
        cmd.freq     = tfreq;
        cmd.divisor  = i_note_divisor;
        cmd.bar      = bar_of(tfreq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    assign o_head       = r_q[r_rd];
    assign o_head_valid = (r_count != '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("command queue overflowed");

endmodule

// File: hw/rtl/tstg_back.sv
module tstg_back
    import tstg_pkg::*;
#(
    parameter int REST_TICKS_PER_UNIT = 10000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BASE_W-1:0] i_base,
    input  t_cmd              i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_pin_level,
    output logic [BAR_W-1:0]  o_level_bar,
    output logic [HP_W-1:0]   o_half_period,
    output logic [TOT_W-1:0]  o_cycle_total,
    output logic              o_note_done,
    output logic              o_busy_res
);

    localparam logic [REST_W-1:0] REST_K = REST_W'(REST_TICKS_PER_UNIT);
    localparam int TOT_PROD_W = PROD_W + TOT_RECIP_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TONE,
        PH_REST,
        PH_GAP
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_LEN,
        SQ_GAP,
        SQ_REST,
        SQ_MUL,
        SQ_HP,
        SQ_TOT,
        SQ_APPLY
    } t_seq;

    function automatic logic [TOT_W-1:0] sat_total(input logic [PROD_W-1:0] x);
        if (x > PROD_W'(TOT_MAX)) begin
            return TOT_MAX;
        end
        return x[TOT_W-1:0];
    endfunction

    // Sequencer and note state.
    t_seq              r_seq,        n_seq;
    t_phase            r_phase,      n_phase;
    logic              r_pin,        n_pin;
    logic [HP_W-1:0]   r_hp,         n_hp;
    logic [HP_W-1:0]   r_hc,         n_hc;
    logic [TOT_W-1:0]  r_cycles,     n_cycles;
    logic [GAP_W-1:0]  r_gap,        n_gap;
    logic              r_div_pend,   n_div_pend;

    // Operands and results of a start in progress.
    logic [TF_W-1:0]   r_f,          n_f;
    logic [DIV_W-1:0]  r_divisor,    n_divisor;
    logic [BAR_W-1:0]  r_bar,        n_bar;
    logic [LEN_W-1:0]  r_len,        n_len;
    logic [GAP_W-1:0]  r_calc_gap,   n_calc_gap;
    logic [HP_W-1:0]   r_calc_hp,    n_calc_hp;
    logic [TOT_W-1:0]  r_calc_total, n_calc_total;
    logic [PROD_W-1:0] r_prod,       n_prod;

    // Output register.
    logic              r_o_valid,    n_o_valid;
    logic              r_o_pin,      n_o_pin;
    logic [BAR_W-1:0]  r_o_bar,      n_o_bar;
    logic [HP_W-1:0]   r_o_hp,       n_o_hp;
    logic [TOT_W-1:0]  r_o_total,    n_o_total;
    logic              r_o_done,     n_o_done;
    logic              r_o_busy,     n_o_busy;

    logic              out_free;
    logic              done;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_quotient;
    logic [HP_W-1:0]   hc_inc;
    logic [TOT_W-1:0]  cyc_dec;
    logic [GAP_W-1:0]  gap_dec;
    logic [PROD_W-1:0] rest_prod;
    logic [GAP_PROD_W-1:0] gap_prod;
    logic [TOT_PROD_W-1:0] tot_prod;

    tstg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign out_free  = !r_o_valid || !i_out_stall;
    assign hc_inc    = r_hc + 1'b1;
    assign cyc_dec   = r_cycles - 1'b1;
    assign gap_dec   = r_gap - 1'b1;
    assign rest_prod = PROD_W'(r_len) * PROD_W'(REST_K);

    // length * 13 / 10 and product / 100 as multiplications by reciprocals.
    assign gap_prod  = GAP_PROD_W'(r_len) * GAP_PROD_W'(GAP_NUM * GAP_RECIP);
    assign tot_prod  = TOT_PROD_W'(r_prod) * TOT_PROD_W'(TOT_RECIP);

    always_comb begin
        case (r_seq)
            SQ_LEN: begin
                div_dividend = DVD_W'(i_base);
                div_divisor  = DVS_W'(r_divisor);
            end
            default: begin
                div_dividend = DVD_W'(HALF_SCALE);
                div_divisor  = r_f;
            end
        endcase
    end

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_pin        = r_pin;
        n_hp         = r_hp;
        n_hc         = r_hc;
        n_cycles     = r_cycles;
        n_gap        = r_gap;
        n_div_pend   = r_div_pend;
        n_f          = r_f;
        n_divisor    = r_divisor;
        n_bar        = r_bar;
        n_len        = r_len;
        n_calc_gap   = r_calc_gap;
        n_calc_hp    = r_calc_hp;
        n_calc_total = r_calc_total;
        n_prod       = r_prod;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_pin      = r_o_pin;
        n_o_bar      = r_o_bar;
        n_o_hp       = r_o_hp;
        n_o_total    = r_o_total;
        n_o_done     = r_o_done;
        n_o_busy     = r_o_busy;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        done         = 1'b0;

        case (r_seq)
            SQ_IDLE: begin
                if (i_head_valid && i_head.is_start) begin
                    o_pop     = 1'b1;
                    n_f       = i_head.freq;
                    n_divisor = i_head.divisor;
                    n_bar     = i_head.bar;
                    if (i_head.divisor == '0) begin
                        n_len = '0;
                        n_seq = SQ_GAP;
                    end else begin
                        n_seq = SQ_LEN;
                    end
                end else if (i_head_valid && out_free) begin
                    o_pop = 1'b1;
                    case (r_phase)
                        PH_TONE: begin
                            if (hc_inc >= r_hp) begin
                                n_hc = '0;
                                if (r_pin) begin
                                    n_pin = 1'b0;
                                end else begin
                                    n_cycles = cyc_dec;
                                    if (cyc_dec == '0) begin
                                        n_pin = 1'b0;
                                        if (r_gap != '0) begin
                                            n_phase = PH_GAP;
                                        end else begin
                                            n_phase = PH_IDLE;
                                            done    = 1'b1;
                                        end
                                    end else begin
                                        n_pin = 1'b1;
                                    end
                                end
                            end else begin
                                n_hc = hc_inc;
                            end
                        end
                        PH_REST: begin
                            n_cycles = cyc_dec;
                            if (cyc_dec == '0) begin
                                n_pin = 1'b0;
                                if (r_gap != '0) begin
                                    n_phase = PH_GAP;
                                end else begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end
                            end
                        end
                        PH_GAP: begin
                            n_gap = gap_dec;
                            if (gap_dec == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_o_valid = 1'b1;
                    n_o_pin   = n_pin;
                    n_o_bar   = '0;
                    n_o_hp    = '0;
                    n_o_total = '0;
                    n_o_done  = done;
                    n_o_busy  = (n_phase != PH_IDLE);
                end
            end
            SQ_LEN: begin
                div_start  = !r_div_pend;
                n_div_pend = 1'b1;
                if (div_done) begin
                    n_div_pend = 1'b0;
                    n_len      = div_quotient[LEN_W-1:0];
                    n_seq      = SQ_GAP;
                end
            end
            SQ_GAP: begin
                n_calc_gap = gap_prod[GAP_SHIFT +: GAP_W];
                n_seq      = (r_f == '0) ? SQ_REST : SQ_MUL;
            end
            SQ_REST: begin
                n_calc_hp    = '0;
                n_calc_total = sat_total(rest_prod);
                n_seq        = SQ_APPLY;
            end
            SQ_MUL: begin
                n_prod = PROD_W'(r_f) * PROD_W'(r_len);
                n_seq  = SQ_HP;
            end
            SQ_HP: begin
                div_start  = !r_div_pend;
                n_div_pend = 1'b1;
                if (div_done) begin
                    n_div_pend = 1'b0;
                    n_calc_hp  = div_quotient[HP_W-1:0];
                    n_seq      = SQ_TOT;
                end
            end
            SQ_TOT: begin
                // The quotient stays far below the 22-bit saturation point.
                n_calc_total = TOT_W'(tot_prod[TOT_PROD_W-1:TOT_SHIFT]);
                n_seq        = SQ_APPLY;
            end
            SQ_APPLY: begin
                if (out_free) begin
                    n_gap    = r_calc_gap;
                    n_hc     = '0;
                    n_hp     = r_calc_hp;
                    n_cycles = r_calc_total;
                    n_pin    = 1'b0;
                    if (r_calc_total != '0) begin
                        n_phase = (r_f != '0) ? PH_TONE : PH_REST;
                        n_pin   = (r_f != '0);
                    end else if (r_calc_gap != '0) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    n_o_valid = 1'b1;
                    n_o_pin   = n_pin;
                    n_o_bar   = r_bar;
                    n_o_hp    = r_calc_hp;
                    n_o_total = r_calc_total;
                    n_o_done  = done;
                    n_o_busy  = (n_phase != PH_IDLE);
                    n_seq     = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SQ_IDLE;
            r_phase    <= PH_IDLE;
            r_pin      <= 1'b0;
            r_hp       <= '0;
            r_hc       <= '0;
            r_cycles   <= '0;
            r_gap      <= '0;
            r_div_pend <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_pin      <= n_pin;
            r_hp       <= n_hp;
            r_hc       <= n_hc;
            r_cycles   <= n_cycles;
            r_gap      <= n_gap;
            r_div_pend <= n_div_pend;
            r_o_valid  <= n_o_valid;
        end
        r_f          <= n_f;
        r_divisor    <= n_divisor;
        r_bar        <= n_bar;
        r_len        <= n_len;
        r_calc_gap   <= n_calc_gap;
        r_calc_hp    <= n_calc_hp;
        r_calc_total <= n_calc_total;
        r_prod       <= n_prod;
        r_o_pin      <= n_o_pin;
        r_o_bar      <= n_o_bar;
        r_o_hp       <= n_o_hp;
        r_o_total    <= n_o_total;
        r_o_done     <= n_o_done;
        r_o_busy     <= n_o_busy;
    end

    assign o_out_valid   = r_o_valid;
    assign o_pin_level   = r_o_pin;
    assign o_level_bar   = r_o_bar;
    assign o_half_period = r_o_hp;
    assign o_cycle_total = r_o_total;
    assign o_note_done   = r_o_done;
    assign o_busy_res    = r_o_busy;

    a_pin_only_in_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_TONE) |-> !r_pin)
        else $error("pin high outside a tone");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GAP) |-> (r_gap != '0))
        else $error("gap phase with an empty gap count");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_done) |-> !r_o_busy)
        else $error("note reported done while still busy");

endmodule

// File: hw/rtl/transposed_square_tone_generator_top.sv
// Square-wave tone generator with pitch transpose. Each input transfer is either a one
// microsecond tick or a note start, and each one yields exactly one result transfer in
// order. A two-entry command queue sits in front of the note engine, so input keeps
// flowing while a result waits to be taken. A tick is handled straight from the idle
// state, so ticks sustain one transfer per cycle while the output is not stalled. A note
// start occupies the engine for up to two divisions by a note-dependent value (base by
// tempo divisor, skipped when that divisor is zero; 500000 by frequency, skipped for a
// rest), done one quotient bit per cycle by a single shared 24-bit restoring divider,
// while the scalings by 13/10 and 1/100 are reciprocal multiplications. A result waits
// until the result register is free, and ticks queued behind a start wait for it. A
// transpose write applies to commands queued after it, a base write to later divisions.
module transposed_square_tone_generator_top
    import tstg_pkg::*;
#(
    parameter int REST_TICKS_PER_UNIT = 10000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [FREQ_W-1:0] i_note_frequency,
    input  logic [DIV_W-1:0]  i_note_divisor,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_pin_level,
    output logic [BAR_W-1:0]  o_level_bar,
    output logic [HP_W-1:0]   o_half_period,
    output logic [TOT_W-1:0]  o_cycle_total,
    output logic              o_note_done,
    output logic              o_busy_res
);

    logic [LVL_W-1:0]  r_level;
    logic [BASE_W-1:0] r_base;
    t_cmd              head;
    logic              head_valid;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_base  <= BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSPOSE: r_level <= i_cfg_wdata[LVL_W-1:0];
                CFG_BASE:      r_base  <= i_cfg_wdata[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tstg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_level          (r_level),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_note_frequency (i_note_frequency),
        .i_note_divisor   (i_note_divisor),
        .o_head           (head),
        .o_head_valid     (head_valid),
        .i_pop            (pop)
    );

    tstg_back #(
        .REST_TICKS_PER_UNIT (REST_TICKS_PER_UNIT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base        (r_base),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pin_level   (o_pin_level),
        .o_level_bar   (o_level_bar),
        .o_half_period (o_half_period),
        .o_cycle_total (o_cycle_total),
        .o_note_done   (o_note_done),
        .o_busy_res    (o_busy_res)
    );

endmodule
